// File: src/vlc_pkg.sv
package vlc_pkg;

   localparam int unsigned CompWidth   = 32;
   localparam int unsigned LimitWidth  = 31;
   localparam int unsigned ProdWidth   = CompWidth + LimitWidth;
   localparam int unsigned SqWidth     = 2 * CompWidth;
   localparam int unsigned RemWidth    = CompWidth + 2;
   localparam int unsigned FifoDepth   = 4;
   localparam logic [LimitWidth-1:0] LimitReset = 31'd65536;

   typedef struct packed {
      logic [CompWidth-1:0] vec_x;
      logic [CompWidth-1:0] vec_y;
      logic [CompWidth-1:0] length;
      logic                 clamped;
   } entry_type;

   typedef struct packed {
      logic push;
   } push_ctl_type;

   function automatic logic [CompWidth-1:0] magnitude(input logic [CompWidth-1:0] v);
      magnitude = v[CompWidth-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// File: src/vector_length_clamp_unit.sv
// channel | dir | tdata fields (lsb first)
// req     | in  | vec_x[31:0], vec_y[31:0]
// rsp     | out | out_x[31:0], out_y[31:0], length[31:0], clamped, 7 zero bits
// csr     | in  | max_length[30:0]
// One word per cycle sustained while the rsp side is not stalled; 70 register
// stages (35 front: magnitudes, squares, sum, 32-stage root; 1 queue write;
// 34 back: scaling multiply, 32-stage divider, output).
// Synchronous reset empties both pipelines and the 4-entry queue.
// A stalled rsp side fills the queue, then holds the front off.
module vector_length_clamp_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // vec_x, vec_y
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // out_x, out_y, length, clamped, pad
   input  logic          csr_wr_en,
   input  logic [30:0]   csr_wr_data
);
   logic [vlc_pkg::LimitWidth-1:0] limit_ff;
   vlc_pkg::push_ctl_type          push_ctl;
   vlc_pkg::entry_type             push_data, pop_data, out_data;
   logic                           full, not_empty, back_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= vlc_pkg::LimitReset;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   vlc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_x(req_tdata[31:0]), .in_y(req_tdata[63:32]),
      .limit(limit_ff), .fifo_full(full),
      .push_ctl(push_ctl), .push_data(push_data)
   );

   vlc_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push_ctl(push_ctl), .push_data(push_data),
      .full(full), .not_empty(not_empty),
      .pop(back_ready), .pop_data(pop_data)
   );

   vlc_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(not_empty), .in_ready(back_ready), .in_data(pop_data),
      .limit(limit_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(out_data)
   );

   assign rsp_tdata = {7'd0, out_data.clamped, out_data.length,
                       out_data.vec_y, out_data.vec_x};
endmodule

// File: src/vlc_front.sv
module vlc_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [vlc_pkg::CompWidth-1:0]          in_x,
   input  logic [vlc_pkg::CompWidth-1:0]          in_y,
   input  logic [vlc_pkg::LimitWidth-1:0]         limit,
   input  logic                                   fifo_full,
   output vlc_pkg::push_ctl_type                  push_ctl,
   output vlc_pkg::entry_type                     push_data
);
   localparam int unsigned W = vlc_pkg::CompWidth;
   localparam int unsigned Last = W + 2;

   logic [Last:0]                  valid_ff;
   logic [W-1:0]                   x_ff [0:Last];
   logic [W-1:0]                   y_ff [0:Last];
   logic [W-1:0]                   mx_ff, my_ff;
   logic [vlc_pkg::SqWidth-1:0]    sqx_ff, sqy_ff;
   logic [vlc_pkg::SqWidth-1:0]    sh_ff [2:Last];
   logic [vlc_pkg::RemWidth-1:0]   rem_ff [2:Last];
   logic [W-1:0]                   q_ff [2:Last];
   logic                           adv;

   assign adv      = !valid_ff[Last] || !fifo_full;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[Last-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [vlc_pkg::RemWidth-1:0] r;
      logic [vlc_pkg::RemWidth-1:0] t;
      if (adv) begin
         x_ff[0]  <= in_x;
         y_ff[0]  <= in_y;
         mx_ff    <= vlc_pkg::magnitude(in_x);
         my_ff    <= vlc_pkg::magnitude(in_y);
         x_ff[1]  <= x_ff[0];
         y_ff[1]  <= y_ff[0];
         sqx_ff   <= vlc_pkg::SqWidth'(mx_ff) * vlc_pkg::SqWidth'(mx_ff);
         sqy_ff   <= vlc_pkg::SqWidth'(my_ff) * vlc_pkg::SqWidth'(my_ff);
         x_ff[2]  <= x_ff[1];
         y_ff[2]  <= y_ff[1];
         sh_ff[2] <= sqx_ff + sqy_ff;
         rem_ff[2] <= '0;
         q_ff[2]  <= '0;
         for (int i = 3; i <= Last; i++) begin
            r = {rem_ff[i-1][vlc_pkg::RemWidth-3:0], sh_ff[i-1][vlc_pkg::SqWidth-1 -: 2]};
            t = {q_ff[i-1], 2'b01};
            x_ff[i]  <= x_ff[i-1];
            y_ff[i]  <= y_ff[i-1];
            sh_ff[i] <= {sh_ff[i-1][vlc_pkg::SqWidth-3:0], 2'b00};
            if (r >= t) begin
               rem_ff[i] <= r - t;
               q_ff[i]   <= {q_ff[i-1][W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= r;
               q_ff[i]   <= {q_ff[i-1][W-2:0], 1'b0};
            end
         end
      end
   end

   assign push_ctl.push     = valid_ff[Last] && !fifo_full;
   assign push_data.vec_x   = x_ff[Last];
   assign push_data.vec_y   = y_ff[Last];
   assign push_data.length  = q_ff[Last];
   assign push_data.clamped = q_ff[Last] > {1'b0, limit};
endmodule

// File: src/vlc_fifo.sv
module vlc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  vlc_pkg::push_ctl_type push_ctl,
   input  vlc_pkg::entry_type    push_data,
   output logic                  full,
   output logic                  not_empty,
   input  logic                  pop,
   output vlc_pkg::entry_type    pop_data
);
   localparam int unsigned D  = vlc_pkg::FifoDepth;
   localparam int unsigned AW = $clog2(D);

   vlc_pkg::entry_type mem [0:D-1];
   logic [AW-1:0]      wp_ff, rp_ff;
   logic [AW:0]        cnt_ff;
   logic               do_pop;

   assign full      = cnt_ff == (AW+1)'(D);
   assign not_empty = cnt_ff != '0;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_ctl.push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push_ctl.push) - (AW+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ctl.push) begin
         mem[wp_ff] <= push_data;
      end
   end
endmodule

// File: src/vlc_back.sv
module vlc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  vlc_pkg::entry_type             in_data,
   input  logic [vlc_pkg::LimitWidth-1:0] limit,
   output logic                           out_valid,
   input  logic                           out_ready,
   output vlc_pkg::entry_type             out_data
);
   localparam int unsigned W    = vlc_pkg::CompWidth;
   localparam int unsigned PW   = vlc_pkg::ProdWidth;
   localparam int unsigned Last = W + 1;

   logic [Last:0]        valid_ff;
   vlc_pkg::entry_type   e_ff [0:W];
   logic [PW-1:0]        nx_ff [0:W];
   logic [PW-1:0]        ny_ff [0:W];
   logic [W-1:0]         rx_ff [0:W];
   logic [W-1:0]         ry_ff [0:W];
   logic [W-1:0]         qx_ff [0:W];
   logic [W-1:0]         qy_ff [0:W];
   vlc_pkg::entry_type   out_ff;
   logic                 adv;

   assign adv       = !valid_ff[Last] || out_ready;
   assign in_ready  = adv;
   assign out_valid = valid_ff[Last];
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[Last-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [W:0]   rx, ry;
      logic [PW-1:0] px, py;
      logic [W-1:0]  mx, my;
      if (adv) begin
         e_ff[0]  <= in_data;
         px = PW'(vlc_pkg::magnitude(in_data.vec_x)) * PW'(limit);
         py = PW'(vlc_pkg::magnitude(in_data.vec_y)) * PW'(limit);
         nx_ff[0] <= {px[W-1:0], {(PW-W){1'b0}}};
         ny_ff[0] <= {py[W-1:0], {(PW-W){1'b0}}};
         rx_ff[0] <= W'(px[PW-1:W]);
         ry_ff[0] <= W'(py[PW-1:W]);
         qx_ff[0] <= '0;
         qy_ff[0] <= '0;
         for (int i = 1; i <= W; i++) begin
            rx = {rx_ff[i-1], nx_ff[i-1][PW-1]};
            ry = {ry_ff[i-1], ny_ff[i-1][PW-1]};
            e_ff[i]  <= e_ff[i-1];
            nx_ff[i] <= {nx_ff[i-1][PW-2:0], 1'b0};
            ny_ff[i] <= {ny_ff[i-1][PW-2:0], 1'b0};
            if (rx >= {1'b0, e_ff[i-1].length}) begin
               rx_ff[i] <= W'(rx - {1'b0, e_ff[i-1].length});
               qx_ff[i] <= {qx_ff[i-1][W-2:0], 1'b1};
            end else begin
               rx_ff[i] <= W'(rx);
               qx_ff[i] <= {qx_ff[i-1][W-2:0], 1'b0};
            end
            if (ry >= {1'b0, e_ff[i-1].length}) begin
               ry_ff[i] <= W'(ry - {1'b0, e_ff[i-1].length});
               qy_ff[i] <= {qy_ff[i-1][W-2:0], 1'b1};
            end else begin
               ry_ff[i] <= W'(ry);
               qy_ff[i] <= {qy_ff[i-1][W-2:0], 1'b0};
            end
         end
         mx = qx_ff[W];
         my = qy_ff[W];
         out_ff.length  <= e_ff[W].length;
         out_ff.clamped <= e_ff[W].clamped;
         if (e_ff[W].clamped) begin
            out_ff.vec_x <= e_ff[W].vec_x[W-1] ? (~mx + 1'b1) : mx;
            out_ff.vec_y <= e_ff[W].vec_y[W-1] ? (~my + 1'b1) : my;
         end else begin
            out_ff.vec_x <= e_ff[W].vec_x;
            out_ff.vec_y <= e_ff[W].vec_y;
         end
      end
   end
endmodule

// File: src/vlc_checker.sv
module vlc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[95:64] == 32'd0 |->
         rsp_tdata[63:0] == 64'd0 && !rsp_tdata[96])
      else $error("zero length with nonzero vector or clamp");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[103:97] == 7'd0)
      else $error("pad bits set");
endmodule

bind vector_length_clamp_unit vlc_checker u_vlc_checker (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
